// ----- design/cmva_pkg.sv -----
`default_nettype none

package cmva_pkg;

    localparam int unsigned SMP_W    = 16;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned TERM_W   = 34;
    localparam int unsigned Y_W      = 40;
    localparam int unsigned ROW_W    = 10;
    localparam int unsigned IN_W     = 160;
    localparam int unsigned OUT_W    = 96;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned MAX_ROWS_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IM    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONJ_MATRIX = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONJ_VECTOR = 4'd3;

    localparam logic signed [SMP_W-1:0] ALPHA_RE_RST = 16'sd16384;
    localparam logic signed [SMP_W-1:0] ALPHA_IM_RST = 16'sd0;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
    localparam logic signed [Y_W-1:0]   Y_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [Y_W-1:0]   Y_MIN   = 40'sh80_0000_0000;

endpackage

`default_nettype wire

// ----- design/cmva_ram.sv -----
`default_nettype none

module cmva_ram #(
    parameter int unsigned WIDTH = 80,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/complex_matrix_vector_accumulate.sv -----
// a row result passes the pipeline stage registers and the output register; the accumulator
// memory is read and written once per cycle; one item per cycle unless the output stalls
// a same-row item directly behind in the pipeline takes the written value from a bypass register
// reset: asynchronous, active low; clears pipeline valid bits, output valid and the config
// registers (alpha = 1.0, no conjugation); accumulator memory is not cleared
`default_nettype none

module complex_matrix_vector_accumulate #(
    parameter int unsigned MAX_ROWS = cmva_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_re, a_im, x_re, x_im, y_in_re, y_in_im, row_index, zero fill
    input  wire logic [cmva_pkg::IN_W-1:0]         s_axis_tdata,
    // first_column
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // y_out_re, y_out_im, row_out, zero fill
    output logic      [cmva_pkg::OUT_W-1:0]        m_axis_tdata,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmva_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cmva_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned ADDR_W = $clog2(MAX_ROWS);
    localparam int unsigned SMP_W  = cmva_pkg::SMP_W;
    localparam int unsigned PROD_W = cmva_pkg::PROD_W;
    localparam int unsigned TERM_W = cmva_pkg::TERM_W;
    localparam int unsigned Y_W    = cmva_pkg::Y_W;
    localparam int unsigned ROW_W  = cmva_pkg::ROW_W;

    // config registers

    logic signed [SMP_W-1:0] alpha_re_reg;
    logic signed [SMP_W-1:0] alpha_im_reg;
    logic                    conj_matrix_reg;
    logic                    conj_vector_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg    <= cmva_pkg::ALPHA_RE_RST;
            alpha_im_reg    <= cmva_pkg::ALPHA_IM_RST;
            conj_matrix_reg <= 1'b0;
            conj_vector_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cmva_pkg::REG_ALPHA_RE:    alpha_re_reg    <= cfg_data;
                cmva_pkg::REG_ALPHA_IM:    alpha_im_reg    <= cfg_data;
                cmva_pkg::REG_CONJ_MATRIX: conj_matrix_reg <= cfg_data[0];
                cmva_pkg::REG_CONJ_VECTOR: conj_vector_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input unpacking

    logic signed [SMP_W-1:0] in_a_re;
    logic signed [SMP_W-1:0] in_a_im;
    logic signed [SMP_W-1:0] in_x_re;
    logic signed [SMP_W-1:0] in_x_im;
    logic signed [Y_W-1:0]   in_y_re;
    logic signed [Y_W-1:0]   in_y_im;
    logic [ROW_W-1:0]        in_row;

    assign in_a_re = s_axis_tdata[15:0];
    assign in_a_im = s_axis_tdata[31:16];
    assign in_x_re = s_axis_tdata[47:32];
    assign in_x_im = s_axis_tdata[63:48];
    assign in_y_re = s_axis_tdata[103:64];
    assign in_y_im = s_axis_tdata[143:104];
    assign in_row  = s_axis_tdata[153:144];

    // pipeline control

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic out_valid_reg;
    logic out_free;
    logic last4_reg;
    logic in_fire;
    logic in_range;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign en4           = !v4_reg || !last4_reg || out_free;
    assign en3           = !v3_reg || en4;
    assign en2           = !v2_reg || en3;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;
    assign in_fire       = s_axis_tvalid && en1;
    assign in_range      = 32'(in_row) < MAX_ROWS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_fire && in_range;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= v4_reg && last4_reg;
            end
        end
    end

    // stage 1: alpha * x products

    logic signed [PROD_W-1:0] m_rr_reg, m_ii_reg, m_ri_reg, m_ir_reg;
    logic signed [SMP_W-1:0]  a_re1_reg, a_im1_reg;
    logic signed [Y_W-1:0]    y_re1_reg, y_im1_reg;
    logic [ROW_W-1:0]         row1_reg;
    logic                     first1_reg, last1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            m_rr_reg   <= alpha_re_reg * in_x_re;
            m_ii_reg   <= alpha_im_reg * in_x_im;
            m_ri_reg   <= alpha_re_reg * in_x_im;
            m_ir_reg   <= alpha_im_reg * in_x_re;
            a_re1_reg  <= in_a_re;
            a_im1_reg  <= in_a_im;
            y_re1_reg  <= in_y_re;
            y_im1_reg  <= in_y_im;
            row1_reg   <= in_row;
            first1_reg <= s_axis_tuser;
            last1_reg  <= s_axis_tlast;
        end
    end

    // stage 2: temp = alpha * x, floor by 2^14, saturated

    function automatic logic signed [SMP_W-1:0] sat_temp(input logic signed [PROD_W:0] s);
        logic signed [PROD_W-14:0] sh;
        sh = s[PROD_W:14];
        if (sh[PROD_W-14:SMP_W-1] == {(PROD_W-SMP_W-12){1'b0}}
            || sh[PROD_W-14:SMP_W-1] == {(PROD_W-SMP_W-12){1'b1}})
            return sh[SMP_W-1:0];
        else if (sh[PROD_W-14])
            return cmva_pkg::SMP_MIN;
        else
            return cmva_pkg::SMP_MAX;
    endfunction

    logic signed [PROD_W:0]  t_re_sum, t_im_sum;
    logic signed [SMP_W-1:0] t_re_next, t_im_next;

    always_comb
    begin
        if (conj_vector_reg)
        begin
            t_re_sum = {m_rr_reg[PROD_W-1], m_rr_reg} + {m_ii_reg[PROD_W-1], m_ii_reg};
            t_im_sum = {m_ri_reg[PROD_W-1], m_ri_reg} - {m_ir_reg[PROD_W-1], m_ir_reg};
        end
        else
        begin
            t_re_sum = {m_rr_reg[PROD_W-1], m_rr_reg} - {m_ii_reg[PROD_W-1], m_ii_reg};
            t_im_sum = {m_ri_reg[PROD_W-1], m_ri_reg} + {m_ir_reg[PROD_W-1], m_ir_reg};
        end
        t_re_next = sat_temp(t_re_sum);
        t_im_next = sat_temp(t_im_sum);
    end

    logic signed [SMP_W-1:0] t_re_reg, t_im_reg;
    logic signed [SMP_W-1:0] a_re2_reg, a_im2_reg;
    logic signed [Y_W-1:0]   y_re2_reg, y_im2_reg;
    logic [ROW_W-1:0]        row2_reg;
    logic                    first2_reg, last2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            t_re_reg   <= t_re_next;
            t_im_reg   <= t_im_next;
            a_re2_reg  <= a_re1_reg;
            a_im2_reg  <= a_im1_reg;
            y_re2_reg  <= y_re1_reg;
            y_im2_reg  <= y_im1_reg;
            row2_reg   <= row1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // stage 3: temp * a products

    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [Y_W-1:0]    y_re3_reg, y_im3_reg;
    logic [ROW_W-1:0]         row3_reg;
    logic                     first3_reg, last3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            p_rr_reg   <= t_re_reg * a_re2_reg;
            p_ii_reg   <= t_im_reg * a_im2_reg;
            p_ri_reg   <= t_re_reg * a_im2_reg;
            p_ir_reg   <= t_im_reg * a_re2_reg;
            y_re3_reg  <= y_re2_reg;
            y_im3_reg  <= y_im2_reg;
            row3_reg   <= row2_reg;
            first3_reg <= first2_reg;
            last3_reg  <= last2_reg;
        end
    end

    // stage 4: term selection by conjugate modes, accumulator read

    logic signed [TERM_W-1:0] e_rr, e_ii, e_ri, e_ir;
    logic signed [TERM_W-1:0] d_re_next, d_im_next;

    assign e_rr = {{(TERM_W-PROD_W){p_rr_reg[PROD_W-1]}}, p_rr_reg};
    assign e_ii = {{(TERM_W-PROD_W){p_ii_reg[PROD_W-1]}}, p_ii_reg};
    assign e_ri = {{(TERM_W-PROD_W){p_ri_reg[PROD_W-1]}}, p_ri_reg};
    assign e_ir = {{(TERM_W-PROD_W){p_ir_reg[PROD_W-1]}}, p_ir_reg};

    always_comb
    begin
        unique case ({conj_matrix_reg, conj_vector_reg})
            2'b00:
            begin
                d_re_next = e_rr - e_ii;
                d_im_next = e_ri + e_ir;
            end
            2'b01:
            begin
                d_re_next = e_rr + e_ii;
                d_im_next = e_ri - e_ir;
            end
            2'b10:
            begin
                d_re_next = e_rr + e_ii;
                d_im_next = e_ir - e_ri;
            end
            default:
            begin
                d_re_next = e_rr - e_ii;
                d_im_next = -e_ri - e_ir;
            end
        endcase
    end

    logic signed [TERM_W-1:0] d_re_reg, d_im_reg;
    logic signed [Y_W-1:0]    y_re4_reg, y_im4_reg;
    logic [ROW_W-1:0]         row4_reg;
    logic                     first4_reg;
    logic                     fwd_hit_reg;
    logic [2*Y_W-1:0]         fwd_data_reg;
    logic [2*Y_W-1:0]         ram_rd_data;
    logic [2*Y_W-1:0]         acc_wr_data;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            d_re_reg     <= d_re_next;
            d_im_reg     <= d_im_next;
            y_re4_reg    <= y_re3_reg;
            y_im4_reg    <= y_im3_reg;
            row4_reg     <= row3_reg;
            first4_reg   <= first3_reg;
            last4_reg    <= last3_reg;
            fwd_data_reg <= acc_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (en4)
        begin
            fwd_hit_reg <= v4_reg && v3_reg && (row4_reg == row3_reg);
        end
    end

    cmva_ram #(
        .WIDTH (2 * Y_W),
        .DEPTH (MAX_ROWS)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (v4_reg && en4),
        .wr_addr (ADDR_W'(row4_reg)),
        .wr_data (acc_wr_data),
        .rd_en   (en4),
        .rd_addr (ADDR_W'(row3_reg)),
        .rd_data (ram_rd_data)
    );

    // accumulate and saturate

    function automatic logic signed [Y_W-1:0] sat_acc(input logic signed [Y_W:0] s);
        if (s[Y_W] == s[Y_W-1])
            return s[Y_W-1:0];
        else if (s[Y_W])
            return cmva_pkg::Y_MIN;
        else
            return cmva_pkg::Y_MAX;
    endfunction

    logic [2*Y_W-1:0]        acc_old;
    logic signed [Y_W-1:0]   base_re, base_im;
    logic signed [Y_W:0]     sum_re, sum_im;
    logic signed [Y_W-1:0]   acc_re_next, acc_im_next;

    always_comb
    begin
        acc_old = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
        if (first4_reg)
        begin
            base_re = y_re4_reg;
            base_im = y_im4_reg;
        end
        else
        begin
            base_re = acc_old[Y_W-1:0];
            base_im = acc_old[2*Y_W-1:Y_W];
        end
        sum_re = {base_re[Y_W-1], base_re}
               + {{(Y_W+1-TERM_W){d_re_reg[TERM_W-1]}}, d_re_reg};
        sum_im = {base_im[Y_W-1], base_im}
               + {{(Y_W+1-TERM_W){d_im_reg[TERM_W-1]}}, d_im_reg};
        acc_re_next = sat_acc(sum_re);
        acc_im_next = sat_acc(sum_im);
    end

    assign acc_wr_data = {acc_im_next, acc_re_next};

    // output register

    logic signed [Y_W-1:0] y_out_re_reg, y_out_im_reg;
    logic [ROW_W-1:0]      row_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && v4_reg && last4_reg)
        begin
            y_out_re_reg <= acc_re_next;
            y_out_im_reg <= acc_im_next;
            row_out_reg  <= row4_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, row_out_reg, y_out_im_reg, y_out_re_reg};

    // checks

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg && last4_reg))
        else $error("result raised without a last-column item");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is free");

    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> v4_reg)
        else $error("bypass active without an item in the accumulate stage");

    a_fwd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !en4) |=> ($stable(fwd_hit_reg) && $stable(row4_reg)))
        else $error("accumulate stage changed while stalled");

endmodule

`default_nettype wire

// ----- verif/tb_complex_matrix_vector_accumulate.sv -----
`timescale 1ns / 100ps

module tb_complex_matrix_vector_accumulate;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PIPE_SETTLE = 12;
    localparam int MAX_DIM     = 8;

    typedef struct {
        logic signed [cmva_pkg::SMP_W-1:0] a_re;
        logic signed [cmva_pkg::SMP_W-1:0] a_im;
        logic signed [cmva_pkg::SMP_W-1:0] x_re;
        logic signed [cmva_pkg::SMP_W-1:0] x_im;
        logic signed [cmva_pkg::Y_W-1:0]   y_re;
        logic signed [cmva_pkg::Y_W-1:0]   y_im;
        logic [cmva_pkg::ROW_W-1:0]        row;
        bit                                first;
        bit                                last;
    } mat_item_t;

    typedef struct {
        logic [cmva_pkg::Y_W-1:0]   y_re;
        logic [cmva_pkg::Y_W-1:0]   y_im;
        logic [cmva_pkg::ROW_W-1:0] row;
    } row_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cmva_pkg::IN_W-1:0]       s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cmva_pkg::OUT_W-1:0]      m_axis_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cmva_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cmva_pkg::CFG_DATA_W-1:0] cfg_data;

    logic signed [cmva_pkg::SMP_W-1:0] cfg_alpha_re;
    logic signed [cmva_pkg::SMP_W-1:0] cfg_alpha_im;
    bit                                cfg_conj_matrix;
    bit                                cfg_conj_vector;

    longint      row_acc_re [cmva_pkg::MAX_ROWS_DEF];
    longint      row_acc_im [cmva_pkg::MAX_ROWS_DEF];
    bit          row_started [cmva_pkg::MAX_ROWS_DEF];
    int          started_rows [$];
    row_result_t pending_rows [$];
    row_result_t want;

    int clk_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int burst_left = 0;

    complex_matrix_vector_accumulate #(
        .MAX_ROWS(cmva_pkg::MAX_ROWS_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        clk_cycles <= clk_cycles + 1;
        if (clk_cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern changes with bits 9:8 of the cycle counter
    always @(posedge clk)
    begin
        case (clk_cycles[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 9) < 7);
            2'd2:    m_axis_tready <= ((clk_cycles % 5) < 3);
            default: m_axis_tready <= ((clk_cycles % 6) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: re %h im %h row %0d",
                             m_axis_tdata[39:0], m_axis_tdata[79:40], m_axis_tdata[89:80]);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (m_axis_tdata[39:0] !== want.y_re || m_axis_tdata[79:40] !== want.y_im ||
                    m_axis_tdata[89:80] !== want.row)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected re %h im %h row %0d, got re %h im %h row %0d",
                                 want.y_re, want.y_im, want.row, m_axis_tdata[39:0],
                                 m_axis_tdata[79:40], m_axis_tdata[89:80]);
                end
            end
        end
    end

    function automatic longint clamp_q14(input longint v);
        if (v > longint'(cmva_pkg::SMP_MAX))
            return longint'(cmva_pkg::SMP_MAX);
        if (v < longint'(cmva_pkg::SMP_MIN))
            return longint'(cmva_pkg::SMP_MIN);
        return v;
    endfunction

    function automatic longint clamp_q28(input longint v);
        if (v > longint'(cmva_pkg::Y_MAX))
            return longint'(cmva_pkg::Y_MAX);
        if (v < longint'(cmva_pkg::Y_MIN))
            return longint'(cmva_pkg::Y_MIN);
        return v;
    endfunction

    task automatic model_accumulate(input mat_item_t it);
        longint ar, ai, xr, xi, al_r, al_i, tr, ti, dr, di;
        row_result_t res;
        ar = it.a_re;
        ai = it.a_im;
        xr = it.x_re;
        xi = it.x_im;
        al_r = cfg_alpha_re;
        al_i = cfg_alpha_im;
        if (!cfg_conj_vector)
        begin
            tr = al_r * xr - al_i * xi;
            ti = al_r * xi + al_i * xr;
        end
        else
        begin
            tr = al_r * xr + al_i * xi;
            ti = al_r * xi - al_i * xr;
        end
        tr = clamp_q14(tr >>> 14);
        ti = clamp_q14(ti >>> 14);
        if (!cfg_conj_matrix && !cfg_conj_vector)
        begin
            dr = tr * ar - ti * ai;
            di = tr * ai + ti * ar;
        end
        else if (!cfg_conj_matrix)
        begin
            dr = tr * ar + ti * ai;
            di = tr * ai - ti * ar;
        end
        else if (!cfg_conj_vector)
        begin
            dr = tr * ar + ti * ai;
            di = ti * ar - tr * ai;
        end
        else
        begin
            dr = tr * ar - ti * ai;
            di = -(tr * ai) - ti * ar;
        end
        if (it.first)
        begin
            row_acc_re[it.row] = it.y_re;
            row_acc_im[it.row] = it.y_im;
        end
        row_acc_re[it.row] = clamp_q28(row_acc_re[it.row] + dr);
        row_acc_im[it.row] = clamp_q28(row_acc_im[it.row] + di);
        if (it.last)
        begin
            res.y_re = row_acc_re[it.row][cmva_pkg::Y_W-1:0];
            res.y_im = row_acc_im[it.row][cmva_pkg::Y_W-1:0];
            res.row  = it.row;
            pending_rows.push_back(res);
        end
    endtask

    function automatic mat_item_t make_item(input logic [15:0] ar, ai, xr, xi,
                                            input logic [39:0] yr, yi,
                                            input int row, input bit first, last);
        mat_item_t it;
        it.a_re  = ar;
        it.a_im  = ai;
        it.x_re  = xr;
        it.x_im  = xi;
        it.y_re  = yr;
        it.y_im  = yi;
        it.row   = row[cmva_pkg::ROW_W-1:0];
        it.first = first;
        it.last  = last;
        return it;
    endfunction

    function automatic logic signed [cmva_pkg::SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return cmva_pkg::SMP_MAX;
            1:       return cmva_pkg::SMP_MIN;
            2:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [cmva_pkg::Y_W-1:0] rand_y();
        case ($urandom_range(0, 7))
            0:       return cmva_pkg::Y_MAX - 40'($urandom_range(0, 1 << 24));
            1:       return cmva_pkg::Y_MIN + 40'($urandom_range(0, 1 << 24));
            2:       return 40'($signed(16'($urandom)));
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_item(input mat_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.row, it.y_im, it.y_re, it.x_im, it.x_re, it.a_im, it.a_re};
        s_axis_tuser  <= it.first;
        s_axis_tlast  <= it.last;
        if (it.first && !row_started[it.row])
        begin
            row_started[it.row] = 1'b1;
            started_rows.push_back(it.row);
        end
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        model_accumulate(it);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cmva_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmva_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cmva_pkg::REG_ALPHA_RE:    cfg_alpha_re = val;
            cmva_pkg::REG_ALPHA_IM:    cfg_alpha_im = val;
            cmva_pkg::REG_CONJ_MATRIX: cfg_conj_matrix = val[0];
            cmva_pkg::REG_CONJ_VECTOR: cfg_conj_vector = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] ar, ai, input bit cm, cv);
        wait_results_drained();
        write_reg(cmva_pkg::REG_ALPHA_RE, ar);
        write_reg(cmva_pkg::REG_ALPHA_IM, ai);
        write_reg(cmva_pkg::REG_CONJ_MATRIX, {15'b0, cm});
        write_reg(cmva_pkg::REG_CONJ_VECTOR, {15'b0, cv});
        cfg_valid <= 1'b0;
    endtask

    // column-major walk over nr rows; finish = 0 leaves the rows open
    task automatic run_matrix(input int nr, nc, input bit finish, input int pause_col);
        int rows [MAX_DIM];
        logic signed [cmva_pkg::SMP_W-1:0] col_xr [MAX_DIM];
        logic signed [cmva_pkg::SMP_W-1:0] col_xi [MAX_DIM];
        int base, stride;
        base   = $urandom_range(0, cmva_pkg::MAX_ROWS_DEF - 1);
        stride = ($urandom_range(0, 1) == 0) ? 1 : 2 * $urandom_range(0, 127) + 1;
        for (int r = 0; r < nr; r++)
            rows[r] = (base + r * stride) % cmva_pkg::MAX_ROWS_DEF;
        for (int c = 0; c < nc; c++)
        begin
            col_xr[c] = rand_sample();
            col_xi[c] = rand_sample();
        end
        for (int c = 0; c < nc; c++)
        begin
            if (c == pause_col)
                wait_results_drained();
            for (int r = 0; r < nr; r++)
                send_item(make_item(rand_sample(), rand_sample(), col_xr[c], col_xi[c],
                                    rand_y(), rand_y(), rows[r], c == 0,
                                    finish && (c == nc - 1)));
        end
    endtask

    // loose items: new rows or continuations of rows already opened
    task automatic send_loose_items(input int n);
        bit first;
        int row;
        for (int i = 0; i < n; i++)
        begin
            first = (started_rows.size() == 0) || ($urandom_range(0, 2) == 0);
            if (first)
                row = $urandom_range(0, cmva_pkg::MAX_ROWS_DEF - 1);
            else
                row = started_rows[$urandom_range(0, started_rows.size() - 1)];
            send_item(make_item(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                                rand_y(), rand_y(), row, first, $urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_config();
        send_item(make_item(16'sd16384, 16'sd0, 16'sd8192, -16'sd8192, 40'sd0, 40'sd0,
                            0, 1'b1, 1'b1));
        send_item(make_item(16'sd1000, -16'sd2000, 16'sd3000, 16'sd4000, 40'sd12345,
                            -40'sd54321, 1023, 1'b1, 1'b0));
        send_item(make_item(-16'sd7000, 16'sd5000, -16'sd100, 16'sd200, rand_y(), rand_y(),
                            1023, 1'b0, 1'b1));
    endtask

    task automatic test_saturation();
        apply_settings(cmva_pkg::SMP_MIN, cmva_pkg::SMP_MIN, 1'b0, 1'b0);
        send_item(make_item(cmva_pkg::SMP_MAX, cmva_pkg::SMP_MIN, cmva_pkg::SMP_MIN,
                            cmva_pkg::SMP_MIN, cmva_pkg::Y_MAX, cmva_pkg::Y_MIN,
                            5, 1'b1, 1'b1));
        send_item(make_item(cmva_pkg::SMP_MIN, cmva_pkg::SMP_MIN, cmva_pkg::SMP_MAX,
                            cmva_pkg::SMP_MAX, cmva_pkg::Y_MIN, cmva_pkg::Y_MAX,
                            6, 1'b1, 1'b1));
        send_item(make_item(cmva_pkg::SMP_MAX, cmva_pkg::SMP_MAX, 16'sd0, 16'sd0,
                            cmva_pkg::Y_MAX, cmva_pkg::Y_MIN, 0, 1'b1, 1'b1));
        apply_settings(cmva_pkg::SMP_MAX, cmva_pkg::SMP_MIN, 1'b0, 1'b0);
        send_item(make_item(cmva_pkg::SMP_MIN, cmva_pkg::SMP_MAX, cmva_pkg::SMP_MIN,
                            cmva_pkg::SMP_MAX, cmva_pkg::Y_MAX, cmva_pkg::Y_MAX,
                            7, 1'b1, 1'b1));
        send_item(make_item(cmva_pkg::SMP_MAX, cmva_pkg::SMP_MAX, cmva_pkg::SMP_MAX,
                            cmva_pkg::SMP_MIN, cmva_pkg::Y_MIN, cmva_pkg::Y_MIN,
                            8, 1'b1, 1'b1));
    endtask

    task automatic test_conjugate_modes();
        for (int m = 0; m < 4; m++)
        begin
            apply_settings(16'sd12000, -16'sd5000, m[1], m[0]);
            send_item(make_item(16'sd9000, -16'sd3000, 16'sd7000, 16'sd11000, 40'sd1 <<< 30,
                                -40'sd1 <<< 29, 2, 1'b1, 1'b0));
            send_item(make_item(-16'sd4000, 16'sd15000, -16'sd6000, 16'sd2500, 40'sd0, 40'sd0,
                                2, 1'b0, 1'b1));
        end
    endtask

    task automatic test_single_column();
        send_item(make_item(16'sd300, 16'sd400, 16'sd500, -16'sd600, 40'sd77, -40'sd88,
                            100, 1'b1, 1'b1));
        send_item(make_item(-16'sd300, 16'sd900, cmva_pkg::SMP_MAX, cmva_pkg::SMP_MIN,
                            -40'sd1, 40'sd1, 100, 1'b1, 1'b1));
        send_item(make_item(cmva_pkg::SMP_MIN, cmva_pkg::SMP_MAX, 16'sd1, -16'sd1,
                            rand_y(), rand_y(), 512, 1'b1, 1'b1));
    endtask

    task automatic test_drain_pause();
        run_matrix(2, 3, 1'b1, 2);
    endtask

    task automatic test_random_matrices(input int n_items);
        int stop_at, phase_end;
        stop_at   = items_sent + n_items;
        phase_end = items_sent;
        while (items_sent < stop_at)
        begin
            if (items_sent >= phase_end)
            begin
                case ($urandom_range(0, 4))
                    0:       apply_settings(cmva_pkg::SMP_MIN, cmva_pkg::SMP_MAX,
                                            $urandom_range(0, 1), $urandom_range(0, 1));
                    1:       apply_settings(cmva_pkg::SMP_MAX, 16'sd0,
                                            $urandom_range(0, 1), $urandom_range(0, 1));
                    2:       apply_settings(cmva_pkg::ALPHA_RE_RST, cmva_pkg::ALPHA_IM_RST,
                                            $urandom_range(0, 1), $urandom_range(0, 1));
                    default: apply_settings(16'($urandom), 16'($urandom),
                                            $urandom_range(0, 1), $urandom_range(0, 1));
                endcase
                phase_end = items_sent + $urandom_range(60, 160);
            end
            case ($urandom_range(0, 9))
                0:       send_loose_items($urandom_range(1, 6));
                1:       run_matrix($urandom_range(1, 4), $urandom_range(1, 5), 1'b0, -1);
                2:       run_matrix(MAX_DIM, $urandom_range(1, MAX_DIM), 1'b1, -1);
                3:       run_matrix(1, $urandom_range(2, MAX_DIM), 1'b1, -1);
                default: run_matrix($urandom_range(1, 4), $urandom_range(1, 6), 1'b1, -1);
            endcase
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        cfg_alpha_re    = cmva_pkg::ALPHA_RE_RST;
        cfg_alpha_im    = cmva_pkg::ALPHA_IM_RST;
        cfg_conj_matrix = 1'b0;
        cfg_conj_vector = 1'b0;
        for (int i = 0; i < cmva_pkg::MAX_ROWS_DEF; i++)
        begin
            row_acc_re[i]  = 0;
            row_acc_im[i]  = 0;
            row_started[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_saturation();
        test_conjugate_modes();
        test_single_column();
        test_drain_pause();
        test_random_matrices(930);

        wait_results_drained();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- complex_matrix_vector_accumulate.f -----
design/cmva_pkg.sv
design/cmva_ram.sv
design/complex_matrix_vector_accumulate.sv
verif/tb_complex_matrix_vector_accumulate.sv
